/* rtl/msd_pkg.sv */
// ----------------------------------------------------------------------------
// Mean and standard deviation package
// Shared constants, derived widths and request and result payload types for
// the mean and population standard deviation core.
// ----------------------------------------------------------------------------
package msd_pkg;

    localparam int LANES       = 4;
    localparam int SAMPLE_BITS = 20;
    localparam int MAX_SAMPLES = 1048576;
    localparam int FRAC_BITS   = 8;

    localparam int VALID_W    = 3;
    localparam int FIXED_W    = 28;
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int SQR_W      = 2 * SAMPLE_BITS;
    localparam int SQ_W       = SQR_W + $clog2(MAX_SAMPLES);
    localparam int PROD_W     = CNT_W + SQ_W;
    localparam int SSQ_W      = 2 * SUM_W;
    localparam int DIV_W      = PROD_W + 2 * FRAC_BITS;
    localparam int ROOT_W     = FIXED_W;
    localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_lane0;
        logic [SAMPLE_BITS-1:0] sample_lane1;
        logic [SAMPLE_BITS-1:0] sample_lane2;
        logic [SAMPLE_BITS-1:0] sample_lane3;
        logic [VALID_W-1:0]     lanes_valid;
        logic                   last_group;
    } msd_in_t;

    typedef struct packed {
        logic [FIXED_W-1:0] mean_fixed;
        logic [FIXED_W-1:0] std_dev_fixed;
        logic [CNT_W-1:0]   sample_count;
        logic               count_overflow;
    } msd_out_t;

endpackage

/* rtl/msd_lane.sv */
// ----------------------------------------------------------------------------
// Accumulation lane
// Squares one sample per cycle and keeps the exact running sum and sum of
// squares of the samples that arrive in this lane.
// ----------------------------------------------------------------------------
module msd_lane
    import msd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   add_en,
    input  logic                   clear,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [SUM_W-1:0]       sum,
    output logic [SQ_W-1:0]        square_sum
);

    logic                   add_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SQR_W-1:0]       square_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]        square_sum_reg;

    // The square is registered before it reaches the accumulator.
    always_ff @(posedge clk)
    begin
        sample_reg <= sample;
        square_reg <= SQR_W'(sample) * SQR_W'(sample);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg        <= 1'b0;
            sum_reg        <= '0;
            square_sum_reg <= '0;
        end
        else
        begin
            add_reg <= add_en & ~clear;
            if (clear)
            begin
                sum_reg        <= '0;
                square_sum_reg <= '0;
            end
            else if (add_reg)
            begin
                sum_reg        <= sum_reg + SUM_W'(sample_reg);
                square_sum_reg <= square_sum_reg + SQ_W'(square_reg);
            end
        end
    end

    assign sum        = sum_reg;
    assign square_sum = square_sum_reg;

endmodule

/* rtl/msd_mul.sv */
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module msd_mul
    import msd_pkg::*;
#(
    parameter int A_W = 8,
    parameter int B_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic             busy,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_B = $clog2(B_W + 1);

    logic             busy_reg;
    logic [CNT_B-1:0] count_reg;
    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   mcand_reg;
    logic [B_W-1:0]   mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_B'(B_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_B'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= P_W'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

/* rtl/msd_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msd_div
    import msd_pkg::*;
#(
    parameter int N_W = 16,
    parameter int D_W = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_B = $clog2(N_W + 1);

    logic             busy_reg;
    logic [CNT_B-1:0] count_reg;
    logic [N_W-1:0]   quo_reg;
    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   div_reg;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_B'(N_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_B'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_reg <= {quo_reg[N_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/msd_sqrt.sv */
// ----------------------------------------------------------------------------
// Serial integer square root
// Digit-by-digit square root that produces one root bit per cycle.
// ----------------------------------------------------------------------------
module msd_sqrt
    import msd_pkg::*;
#(
    parameter int R_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [2*R_W-1:0] radicand,
    output logic             busy,
    output logic [R_W-1:0]   root
);

    localparam int CNT_B = $clog2(R_W + 1);

    logic             busy_reg;
    logic [CNT_B-1:0] count_reg;
    logic [2*R_W-1:0] rad_reg;
    logic [R_W:0]     rem_reg;
    logic [R_W-1:0]   root_reg;
    logic [R_W+1:0]   rem_shift;
    logic [R_W+1:0]   trial;
    logic [R_W+1:0]   diff;
    logic             fits;

    assign rem_shift = {rem_reg[R_W-1:0], rad_reg[2*R_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign diff      = rem_shift - trial;
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_B'(R_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_B'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? diff[R_W:0] : rem_shift[R_W:0];
            root_reg <= {root_reg[R_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

/* rtl/mean_and_std_deviation_core.sv */
// ----------------------------------------------------------------------------
// Mean and population standard deviation core
// Accumulates groups of four samples in parallel lanes and, at the end of a
// data set, reports the mean and standard deviation in Q20.8 fixed point.
// ----------------------------------------------------------------------------
// While a data set streams in, the core takes one request of up to four
// samples every cycle; the first lanes_valid lanes are used (values above
// four count as four). Each lane keeps an exact integer sum and sum of
// squares. The request flagged last_group closes the data set: the core then
// stops taking requests while it drains the lane pipeline, merges the four
// lanes (one per cycle), forms N*Q - S*S with two shift-and-add multipliers,
// and runs a one-bit-per-cycle divider three times (mean, then two divisions
// by N) followed by a square root. The 97-bit serial divider accounts for
// most of that pause. The result waits in an output register, so a new data
// set can start streaming while it is unclaimed.
// Samples beyond the count limit are dropped and count_overflow is raised.
// ----------------------------------------------------------------------------
module mean_and_std_deviation_core
    import msd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     sample_valid,
    output logic     sample_ready,
    input  msd_in_t  sample_data,
    output logic     result_valid,
    input  logic     result_ready,
    output msd_out_t result_data
);

    typedef enum logic [3:0] {
        S_ACCUM,
        S_DRAIN,
        S_MERGE,
        S_MUL,
        S_SUB,
        S_VAR1,
        S_VAR2,
        S_SQRT,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      samples_seen_reg;
    logic                  overflow_seen_reg;
    logic [CNT_W-1:0]      n_reg;
    logic                  ovf_reg;
    logic [LANE_IDX_W-1:0] merge_idx_reg;
    logic [SUM_W-1:0]      s_total_reg;
    logic [SQ_W-1:0]       q_total_reg;
    logic [DIV_W-1:0]      dividend_reg;
    logic [FIXED_W-1:0]    mean_reg;
    logic [FIXED_W-1:0]    sd_reg;
    logic                  mul_start_reg;
    logic                  div_start_reg;
    logic                  sqrt_start_reg;
    logic                  result_valid_reg;
    msd_out_t              result_reg;

    logic [SAMPLE_BITS-1:0] lane_sample [LANES];
    logic [SUM_W-1:0]       lane_sum [LANES];
    logic [SQ_W-1:0]        lane_square_sum [LANES];
    logic [LANES-1:0]       lane_add;
    logic                   lane_clear;

    logic                   sample_accept;
    logic [VALID_W-1:0]     valid_clamped;
    logic [CNT_W-1:0]       room;
    logic                   short_room;
    logic [VALID_W-1:0]     taken;

    logic [PROD_W-1:0]      prod_nq;
    logic [SSQ_W-1:0]       prod_ss;
    logic [PROD_W-1:0]      ss_ext;
    logic [PROD_W-1:0]      var_num;
    logic                   mul_nq_busy;
    logic                   mul_ss_busy;
    logic                   div_busy;
    logic                   sqrt_busy;
    logic [DIV_W-1:0]       div_dividend;
    logic [DIV_W-1:0]       div_quotient;
    logic [2*ROOT_W-1:0]    radicand;
    logic [ROOT_W-1:0]      root;
    logic                   units_idle;
    logic                   result_free;
    logic                   mul_start_next;
    logic                   div_start_next;
    logic                   sqrt_start_next;

    // Lane order in the request matches lane index order.
    assign lane_sample[0] = sample_data.sample_lane0;
    assign lane_sample[1] = sample_data.sample_lane1;
    assign lane_sample[2] = sample_data.sample_lane2;
    assign lane_sample[3] = sample_data.sample_lane3;

    assign sample_ready  = (state_reg == S_ACCUM);
    assign sample_accept = sample_valid && sample_ready;

    // A request may carry more samples than the count still has room for.
    // Lanes are filled in order, so only the first "room" lanes are kept.
    assign valid_clamped = (sample_data.lanes_valid > VALID_W'(LANES)) ?
                           VALID_W'(LANES) : sample_data.lanes_valid;
    assign room          = CNT_W'(MAX_SAMPLES) - samples_seen_reg;
    assign short_room    = (room < CNT_W'(valid_clamped));
    assign taken         = short_room ? room[VALID_W-1:0] : valid_clamped;

    assign lane_clear = (state_reg == S_MERGE) &&
                        (merge_idx_reg == LANE_IDX_W'(LANES - 1));

    genvar k;
    generate
        for (k = 0; k < LANES; k++)
        begin : g_lane
            assign lane_add[k] = sample_accept && (VALID_W'(k) < taken);

            msd_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .add_en     (lane_add[k]),
                .clear      (lane_clear),
                .sample     (lane_sample[k]),
                .sum        (lane_sum[k]),
                .square_sum (lane_square_sum[k])
            );
        end
    endgenerate

    // N*Q and S*S run side by side; their difference is N^2 times the
    // variance and is clamped at zero.
    msd_mul #(.A_W(SQ_W), .B_W(CNT_W)) u_mul_nq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (q_total_reg),
        .b       (n_reg),
        .busy    (mul_nq_busy),
        .product (prod_nq)
    );

    msd_mul #(.A_W(SUM_W), .B_W(SUM_W)) u_mul_ss (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (s_total_reg),
        .b       (s_total_reg),
        .busy    (mul_ss_busy),
        .product (prod_ss)
    );

    assign ss_ext  = PROD_W'(prod_ss);
    assign var_num = (prod_nq >= ss_ext) ? (prod_nq - ss_ext) : '0;

    // The divider first forms the mean alongside the multipliers, then
    // divides the scaled variance numerator by N twice, which equals one
    // floor division by N squared.
    assign div_dividend = (state_reg == S_MUL) ?
                          (DIV_W'(s_total_reg) << FRAC_BITS) : dividend_reg;

    msd_div #(.N_W(DIV_W), .D_W(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (n_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Any radicand at or above 2^56 gives a root that saturates the field
    // anyway, so the radicand is clamped to the largest 56-bit value.
    assign radicand = (|div_quotient[DIV_W-1:2*ROOT_W]) ?
                      '1 : div_quotient[2*ROOT_W-1:0];

    msd_sqrt #(.R_W(ROOT_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start_reg),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign units_idle = !mul_start_reg && !div_start_reg && !sqrt_start_reg &&
                        !mul_nq_busy && !mul_ss_busy && !div_busy && !sqrt_busy;

    assign result_free = !result_valid_reg || result_ready;

    // Start pulses for the arithmetic units. The multipliers and the mean
    // division start together once the last lane is merged into a nonempty
    // set; the two variance divisions and the root follow in turn.
    assign mul_start_next  = lane_clear && (n_reg != '0);
    assign div_start_next  = mul_start_next || (state_reg == S_SUB) ||
                             ((state_reg == S_VAR1) && units_idle);
    assign sqrt_start_next = (state_reg == S_VAR2) && units_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_ACCUM;
            samples_seen_reg  <= '0;
            overflow_seen_reg <= 1'b0;
            n_reg             <= '0;
            ovf_reg           <= 1'b0;
            merge_idx_reg     <= '0;
            s_total_reg       <= '0;
            q_total_reg       <= '0;
            dividend_reg      <= '0;
            mean_reg          <= '0;
            sd_reg            <= '0;
            mul_start_reg     <= 1'b0;
            div_start_reg     <= 1'b0;
            sqrt_start_reg    <= 1'b0;
            result_valid_reg  <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            mul_start_reg  <= mul_start_next;
            div_start_reg  <= div_start_next;
            sqrt_start_reg <= sqrt_start_next;

            // In S_DONE the output register is reloaded below instead.
            if (result_valid_reg && result_ready && (state_reg != S_DONE))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_ACCUM:
                begin
                    if (sample_accept)
                    begin
                        samples_seen_reg <= samples_seen_reg + CNT_W'(taken);
                        if (short_room)
                        begin
                            overflow_seen_reg <= 1'b1;
                        end
                        if (sample_data.last_group)
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end

                // The lanes add the closing request in the cycle after it is
                // taken; the count is already final here.
                S_DRAIN:
                begin
                    n_reg             <= samples_seen_reg;
                    ovf_reg           <= overflow_seen_reg;
                    samples_seen_reg  <= '0;
                    overflow_seen_reg <= 1'b0;
                    merge_idx_reg     <= '0;
                    s_total_reg       <= '0;
                    q_total_reg       <= '0;
                    state_reg         <= S_MERGE;
                end

                S_MERGE:
                begin
                    s_total_reg   <= s_total_reg + lane_sum[merge_idx_reg];
                    q_total_reg   <= q_total_reg + lane_square_sum[merge_idx_reg];
                    merge_idx_reg <= merge_idx_reg + 1'b1;
                    if (lane_clear)
                    begin
                        if (n_reg == '0)
                        begin
                            // An empty data set reports zero mean and spread.
                            mean_reg  <= '0;
                            sd_reg    <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end

                S_MUL:
                begin
                    if (units_idle)
                    begin
                        mean_reg  <= (|div_quotient[DIV_W-1:FIXED_W]) ?
                                     '1 : div_quotient[FIXED_W-1:0];
                        state_reg <= S_SUB;
                    end
                end

                S_SUB:
                begin
                    dividend_reg <= DIV_W'(var_num) << (2 * FRAC_BITS);
                    state_reg    <= S_VAR1;
                end

                S_VAR1:
                begin
                    if (units_idle)
                    begin
                        dividend_reg <= div_quotient;
                        state_reg    <= S_VAR2;
                    end
                end

                S_VAR2:
                begin
                    if (units_idle)
                    begin
                        state_reg <= S_SQRT;
                    end
                end

                S_SQRT:
                begin
                    if (units_idle)
                    begin
                        sd_reg    <= root;
                        state_reg <= S_DONE;
                    end
                end

                // Hold here until the output register can take the result.
                S_DONE:
                begin
                    if (result_free)
                    begin
                        result_reg.mean_fixed     <= mean_reg;
                        result_reg.std_dev_fixed  <= sd_reg;
                        result_reg.sample_count   <= n_reg;
                        result_reg.count_overflow <= ovf_reg;
                        result_valid_reg          <= 1'b1;
                        state_reg                 <= S_ACCUM;
                    end
                end

                default:
                begin
                    state_reg <= S_ACCUM;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule
